[design/lpp_pkg.sv]
// Shared types and constants of the lidar packet parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpp_pkg;

  localparam logic [7:0] FrameMark = 8'hFA;
  localparam int         FrameLen  = 22;
  localparam int         FillSat   = 23;
  localparam int         IdxW      = 5;
  localparam logic [8:0] AngleBase = 9'h0A0;
  localparam int         ChkBits   = 15;
  localparam int         ChkBytes  = 20;
  // ten words, each shifted at most nine places: 16 + 10 bits
  localparam int         AccW      = 26;

  typedef enum logic {
    CMD_STORE,
    CMD_CHECK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IdxW-1:0]  addr;
    logic [7:0]       data;
  } cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DRAIN,
    ENG_EMIT
  } eng_state_e;

endpackage

`default_nettype wire

[design/lpp_front.sv]
// Front end: tracks the frame fill count and classifies each byte.
// Depends on lpp_pkg.
`default_nettype none

module lpp_front
  import lpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [IdxW-1:0] fill_q, fill_d;

  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_STORE;
    cmd_o.addr  = fill_q;
    cmd_o.data  = rx_byte_i;
    fill_d      = fill_q;
    if (accept_i) begin
      if (rx_byte_i == FrameMark) begin
        push_o     = 1'b1;
        cmd_o.addr = '0;
        cmd_o.kind = (fill_q == IdxW'(FrameLen)) ? CMD_CHECK : CMD_STORE;
        fill_d     = IdxW'(1);
      end else if (fill_q < IdxW'(FrameLen)) begin
        push_o = 1'b1;
        fill_d = fill_q + IdxW'(1);
      end else begin
        fill_d = IdxW'(FillSat);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

[design/lpp_cmd_fifo.sv]
// Two-entry command queue between front end and frame engine.
// Depends on lpp_pkg.
`default_nettype none

module lpp_cmd_fifo
  import lpp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      head_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/lpp_engine.sv]
// Frame engine: owns the frame buffer, stores bytes, walks a stored frame
// for the checksum and drives the result register. Depends on lpp_pkg.
`default_nettype none

module lpp_engine
  import lpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      rotation_speed_o,
  output logic signed [10:0] angle_index_o,
  output logic [7:0]       dist_a_o,
  output logic [7:0]       dist_b_o,
  output logic [7:0]       dist_c_o,
  output logic [7:0]       dist_d_o
);

  logic [7:0] frame_mem [FrameLen];

  eng_state_e      state_q, state_d;
  logic [IdxW-1:0] rd_addr_q, rd_addr_d;
  logic [IdxW-1:0] rd_idx_q;
  logic            dv_q;
  logic [7:0]      rd_data_q;
  logic            issue;
  logic            mem_we;
  logic            acc_clr;
  logic            emit;

  logic [AccW-1:0] acc_q;
  logic [7:0]      lo_q;
  logic [7:0]      b1_q, spd_lo_q, spd_hi_q, da_q, db_q, dc_q, dd_q, exp_lo_q, exp_hi_q;

  logic [15:0] fold;
  logic        match;
  logic        out_free;
  logic [8:0]  angle_diff;

  assign fold     = {1'b0, acc_q[ChkBits-1:0]} + 16'(acc_q[AccW-1:ChkBits]);
  assign match    = ({1'b0, fold[ChkBits-1:0]} == {exp_hi_q, exp_lo_q});
  assign out_free = !out_valid_o || out_ready_i;
  assign angle_diff = {1'b0, b1_q} - AngleBase;

  always_comb begin
    state_d   = state_q;
    rd_addr_d = rd_addr_q;
    issue     = 1'b0;
    mem_we    = 1'b0;
    pop_o     = 1'b0;
    acc_clr   = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ENG_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_STORE) begin
            mem_we = 1'b1;
            pop_o  = 1'b1;
          end else begin
            acc_clr   = 1'b1;
            rd_addr_d = '0;
            state_d   = ENG_SCAN;
          end
        end
      end
      ENG_SCAN: begin
        issue = 1'b1;
        if (rd_addr_q == IdxW'(FrameLen - 1)) begin
          state_d = ENG_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + IdxW'(1);
        end
      end
      ENG_DRAIN: begin
        state_d = ENG_EMIT;
      end
      ENG_EMIT: begin
        // marker is stored as byte 0 once the old frame is settled
        if (!match || out_free) begin
          emit    = match;
          mem_we  = 1'b1;
          pop_o   = 1'b1;
          state_d = ENG_IDLE;
        end
      end
      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[cmd_i.addr] <= cmd_i.data;
    end
    rd_data_q <= frame_mem[rd_addr_q];
  end

  // byte stream from the buffer: checksum words and captured fields
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_q;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (dv_q) begin
      if (!rd_idx_q[0]) begin
        lo_q <= rd_data_q;
      end else if (rd_idx_q < IdxW'(ChkBytes)) begin
        acc_q <= {acc_q[AccW-2:0], 1'b0} + AccW'({rd_data_q, lo_q});
      end
    end
    if (dv_q) begin
      case (rd_idx_q)
        5'd1:    b1_q     <= rd_data_q;
        5'd2:    spd_lo_q <= rd_data_q;
        5'd3:    spd_hi_q <= rd_data_q;
        5'd4:    da_q     <= rd_data_q;
        5'd8:    db_q     <= rd_data_q;
        5'd12:   dc_q     <= rd_data_q;
        5'd16:   dd_q     <= rd_data_q;
        5'd20:   exp_lo_q <= rd_data_q;
        5'd21:   exp_hi_q <= rd_data_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rotation_speed_o <= {spd_hi_q, spd_lo_q};
      angle_index_o    <= signed'({angle_diff, 2'b00});
      dist_a_o         <= da_q;
      dist_b_o         <= db_q;
      dist_c_o         <= dc_q;
      dist_d_o         <= dd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      rd_addr_q   <= '0;
      dv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      dv_q      <= issue;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/lidar_packet_parser_core.sv]
// Top level of the lidar packet parser: front end, command queue, engine.
// Depends on lpp_pkg, lpp_front, lpp_cmd_fifo and lpp_engine.
`default_nettype none

// Byte-stream frame checker for a scanning rangefinder link. Each accepted
// rx_byte transaction is classified by the front end against a saturating
// fill count and queued (two entries) for the frame engine, which owns the
// 22-byte frame buffer. A plain byte is simply stored, a byte past the
// 22nd is dropped at once. A 0xFA marker that closes a full 22-byte frame
// starts a check: the engine reads the buffer one byte per cycle through its
// single registered read port, folding ten words into the 15-bit checksum,
// then passes through DRAIN and EMIT and, after any wait for the result
// register, stores the marker as byte 0. A match produces one result
// transaction (speed, angle index, four distance low bytes) held in an
// output register; the input keeps accepting while the queue has room.
// No clearing pass is needed after reset.
module lidar_packet_parser_core
  import lpp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [15:0]        rotation_speed_o,
  output logic signed [10:0] angle_index_o,
  output logic [7:0]         dist_a_o,
  output logic [7:0]         dist_b_o,
  output logic [7:0]         dist_c_o,
  output logic [7:0]         dist_d_o
);

  logic fifo_full;
  logic fifo_valid;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // queue full is the only input stall
  assign in_ready_o = !fifo_full;

  lpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_valid_i && in_ready_o),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  lpp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .head_o  (head_cmd)
  );

  lpp_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (fifo_valid),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rotation_speed_o (rotation_speed_o),
    .angle_index_o    (angle_index_o),
    .dist_a_o         (dist_a_o),
    .dist_b_o         (dist_b_o),
    .dist_c_o         (dist_c_o),
    .dist_d_o         (dist_d_o)
  );

endmodule

`default_nettype wire
